// ===== rtl/assert_macros.svh =====
// Assertion macros for the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packer check failed");

// Next-cycle implication.
`define LBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packer check failed");

`endif

// ===== rtl/lbp_pkg.sv =====
// Package for the LSB-first bit packer: opcodes, widths and shared types.
package lbp_pkg;

   localparam int DefMaxFieldWidth = 16;
   localparam int ValueBits        = 16;
   localparam int WidthBits        = 5;
   localparam int NumKinds         = 4;
   localparam int IndexBits        = 2;
   localparam logic [WidthBits-1:0] WidthReset = 5'd8;

   typedef enum logic [2:0] {
      OP_KIND_ONE   = 3'd0,
      OP_KIND_TWO   = 3'd1,
      OP_KIND_THREE = 3'd2,
      OP_KIND_FOUR  = 3'd3,
      OP_CHAR       = 3'd4,
      OP_BIT        = 3'd5,
      OP_FLUSH      = 3'd6
   } opcode_type;

   typedef enum logic [IndexBits-1:0] {
      REG_WIDTH_ONE   = 2'd0,
      REG_WIDTH_TWO   = 2'd1,
      REG_WIDTH_THREE = 2'd2,
      REG_WIDTH_FOUR  = 2'd3
   } reg_index_type;

   // Bytes completed by one item; byte0 goes out first.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } result_type;

endpackage

// ===== rtl/lbp_pack_unit.sv =====
// Combinational packer: merges one item into the partial byte.
module lbp_pack_unit #(
   parameter int MAX_FIELD_WIDTH = lbp_pkg::DefMaxFieldWidth
) (
   input  logic [2:0]                                           opcode,
   input  logic [lbp_pkg::ValueBits-1:0]                        field_value,
   input  logic [lbp_pkg::NumKinds-1:0][lbp_pkg::WidthBits-1:0] widths,
   input  logic [7:0]                                           pending,
   input  logic [2:0]                                           offset,
   output lbp_pkg::result_type                                  result,
   output logic [7:0]                                           pending_next,
   output logic [2:0]                                           offset_next
);

   localparam int EffMax = (MAX_FIELD_WIDTH < lbp_pkg::ValueBits) ?
                           MAX_FIELD_WIDTH : lbp_pkg::ValueBits;
   localparam logic [lbp_pkg::WidthBits-1:0] EffMaxW = lbp_pkg::WidthBits'(EffMax);

   logic [lbp_pkg::WidthBits-1:0] w_sel;
   logic [lbp_pkg::WidthBits-1:0] w_eff;
   logic [lbp_pkg::ValueBits-1:0] src;
   logic [lbp_pkg::ValueBits:0]   mask_w;
   logic [lbp_pkg::ValueBits-1:0] masked;
   logic [22:0]                   acc;
   logic [4:0]                    total;
   logic [7:0]                    rem;
   logic [7:0]                    rem_mask;

   always_comb begin
      src   = field_value;
      w_sel = '0;
      unique case (opcode)
         lbp_pkg::OP_KIND_ONE,
         lbp_pkg::OP_KIND_TWO,
         lbp_pkg::OP_KIND_THREE,
         lbp_pkg::OP_KIND_FOUR: begin
            w_sel = widths[opcode[1:0]];
         end
         lbp_pkg::OP_CHAR: begin
            w_sel = 5'd8;
         end
         lbp_pkg::OP_BIT: begin
            w_sel = 5'd1;
         end
         default: begin
            w_sel = '0;
         end
      endcase
      w_eff  = (w_sel > EffMaxW) ? EffMaxW : w_sel;
      mask_w = ((lbp_pkg::ValueBits+1)'(1) << w_eff) - (lbp_pkg::ValueBits+1)'(1);
      masked = src & mask_w[lbp_pkg::ValueBits-1:0];
      acc    = {15'd0, pending} | ({7'd0, masked} << offset);
      total  = {2'd0, offset} + w_eff;
   end

   always_comb begin
      priority if (total[4]) begin
         rem = {1'b0, acc[22:16]};
      end else if (total[3]) begin
         rem = acc[15:8];
      end else begin
         rem = acc[7:0];
      end
      rem_mask = (8'd1 << total[2:0]) - 8'd1;

      if (opcode == lbp_pkg::OP_FLUSH) begin
         result.count = (offset != 3'd0) ? 2'd1 : 2'd0;
         result.byte0 = pending;
         result.byte1 = '0;
         pending_next = '0;
         offset_next  = '0;
      end else begin
         result.count = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
         result.byte0 = acc[7:0];
         result.byte1 = acc[15:8];
         pending_next = rem & rem_mask;
         offset_next  = total[2:0];
      end
   end

endmodule

// ===== rtl/lbp_out_stage.sv =====
// Result register: up to two bytes, handed out one per cycle on rsp_tready.
module lbp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lbp_pkg::result_type result,
   output logic                can_load,
   output logic [1:0]          count,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // packed_byte[7:0]
   output logic                rsp_tlast    // last_byte
);

   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] cur_ff, cur_in;
   logic [7:0] nxt_ff, nxt_in;

   assign can_load   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = cur_ff;
   assign rsp_tlast  = (cnt_ff == 2'd1);
   assign count      = cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      priority if (load) begin
         cnt_in = result.count;
         cur_in = result.byte0;
         nxt_in = result.byte1;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_in = cnt_ff - 2'd1;
         cur_in = nxt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
   end

endmodule

// ===== rtl/lsb_first_bit_packer_core.sv =====
// LSB-first bit packer: item register, packing logic and byte output register.
// An accepted item goes from the item register through the packing logic into
// the byte output register. Throughput: one item per cycle while rsp_tready is
// high for items of up to one byte; a two-byte item holds back the next item.
// Reset (synchronous): widths back to 8, partial byte and bit position cleared.
module lsb_first_bit_packer_core #(
   parameter int MAX_FIELD_WIDTH = lbp_pkg::DefMaxFieldWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lbp_pkg::ValueBits-1:0] req_tdata,   // field_value[15:0]
   input  logic [2:0]                    req_tuser,   // opcode[2:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // packed_byte[7:0]
   output logic                          rsp_tlast,   // last_byte
   input  logic                          csr_we,
   input  logic [lbp_pkg::IndexBits-1:0] csr_index,
   input  logic [lbp_pkg::WidthBits-1:0] csr_wdata
);

   `include "assert_macros.svh"

   logic                                           in_valid_ff;
   logic [2:0]                                     in_op_ff;
   logic [lbp_pkg::ValueBits-1:0]                  in_value_ff;
   logic [7:0]                                     pending_ff, pending_in;
   logic [2:0]                                     bit_offset_ff, bit_offset_in;
   logic [lbp_pkg::NumKinds-1:0][lbp_pkg::WidthBits-1:0] widths_ff;
   lbp_pkg::result_type                            result;
   logic                                           can_load;
   logic                                           advance;
   logic [1:0]                                     out_count;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser;
         in_value_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widths_ff <= {lbp_pkg::NumKinds{lbp_pkg::WidthReset}};
      end else if (csr_we) begin
         unique case (lbp_pkg::reg_index_type'(csr_index))
            lbp_pkg::REG_WIDTH_ONE:   widths_ff[0] <= csr_wdata;
            lbp_pkg::REG_WIDTH_TWO:   widths_ff[1] <= csr_wdata;
            lbp_pkg::REG_WIDTH_THREE: widths_ff[2] <= csr_wdata;
            lbp_pkg::REG_WIDTH_FOUR:  widths_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   lbp_pack_unit #(
      .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
   ) u_pack (
      .opcode      (in_op_ff),
      .field_value (in_value_ff),
      .widths      (widths_ff),
      .pending     (pending_ff),
      .offset      (bit_offset_ff),
      .result      (result),
      .pending_next(pending_in),
      .offset_next (bit_offset_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         bit_offset_ff <= '0;
      end else if (advance) begin
         pending_ff    <= pending_in;
         bit_offset_ff <= bit_offset_in;
      end
   end

   lbp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .count     (out_count),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // Partial byte never holds bits at or above the bit position.
   `LBP_ASSERT_IMP(a_pending_clean, clock, reset, 1'b1, (pending_ff >> bit_offset_ff) == 8'd0)
   // Second byte of a pair follows as the last one.
   `LBP_ASSERT_NEXT(a_pair_tail, clock, reset, (out_count == 2'd2) && rsp_tready,
                    rsp_tvalid && rsp_tlast)
   // Packer only hands over when the output register is free.
   `LBP_ASSERT_IMP(a_no_overrun, clock, reset, advance,
                   (out_count == 2'd0) || ((out_count == 2'd1) && rsp_tready))

endmodule
